// ===== sv/pacs_pkg.sv =====
// shared types and constants for the pixel-art corner smoothing unit
package pacs_pkg;

  localparam int PIX_W = 32;
  localparam int CH_W  = 8;
  localparam int NCH   = 4;
  localparam int SUM_W = 10;   // up to four 8-bit values summed per channel
  localparam int CNT_W = 3;    // match count 0..4
  localparam int INV_W = 16;   // inverse level, unsigned 8.8
  localparam int DIV_W = 10;   // floor(count * inv / 256) fits in 10 bits
  localparam int NDIAG = 4;

  localparam logic [INV_W-1:0] INV_RESET = 16'd842;
  localparam logic [CH_W-1:0]  ALPHA_MIN = 8'd128;

  // input request: 3x3 window, alpha 31:24 red 23:16 green 15:8 blue 7:0
  typedef struct packed {
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] north;
    logic [PIX_W-1:0] south;
    logic [PIX_W-1:0] west;
    logic [PIX_W-1:0] east;
    logic [PIX_W-1:0] north_west;
    logic [PIX_W-1:0] north_east;
    logic [PIX_W-1:0] south_west;
    logic [PIX_W-1:0] south_east;
  } in_t;

  // result request
  typedef struct packed {
    logic [PIX_W-1:0] result_pixel;
    logic             was_smoothed;
  } out_t;

  // channel sums and divisor, leaving the match stages
  typedef struct packed {
    logic [NCH-1:0][SUM_W-1:0] sums;
    logic [DIV_W-1:0]          divisor;
    logic [PIX_W-1:0]          center;
    logic                      hit;
  } acc_t;

  // per-channel quotients, leaving the divider
  typedef struct packed {
    logic [NCH-1:0][SUM_W-1:0] quot;
    logic [PIX_W-1:0]          center;
    logic                      hit;
  } quo_t;

endpackage

// ===== sv/pacs_match.sv =====
// window capture, diagonal matching, channel sums and divisor
module pacs_match (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_vld,
  input  pacs_pkg::in_t              item,
  input  logic [pacs_pkg::INV_W-1:0] inv_level,
  output logic                       out_vld,
  output pacs_pkg::acc_t             acc
);
  import pacs_pkg::*;

  // side pixel qualifies against one diagonal
  function automatic logic qualify(input logic [PIX_W-1:0] side,
                                   input logic [PIX_W-1:0] vert,
                                   input logic [PIX_W-1:0] corner,
                                   input logic [PIX_W-1:0] across_row,
                                   input logic [PIX_W-1:0] across_col);
    qualify = (side[PIX_W-1 -: CH_W] > ALPHA_MIN) && (side == vert) &&
              ((side != corner) || (side != across_row) || (side != across_col));
  endfunction

  in_t                       win;
  logic                      win_vld;
  logic [NDIAG-1:0]          flags;
  logic [NDIAG-1:0][PIX_W-1:0] sides;
  logic [NCH-1:0][SUM_W-1:0] sums_next;
  logic [NCH-1:0][SUM_W-1:0] sums;
  logic [CNT_W-1:0]          cnt_next;
  logic [CNT_W-1:0]          cnt;
  logic [PIX_W-1:0]          ctr;
  logic                      sum_vld;
  logic [CNT_W+INV_W-1:0]    prod;
  logic [DIV_W-1:0]          div_raw;

  // stage 1: capture the window
  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld <= 1'b0;
    end else begin
      win_vld <= in_vld;
    end
    win <= item;
  end

  // diagonal tests in the fixed order nw, sw, ne, se
  always_comb begin
    flags[0] = qualify(win.west, win.north, win.north_west, win.north_east,
                       win.south_west);
    flags[1] = qualify(win.west, win.south, win.south_west, win.south_east,
                       win.north_west);
    flags[2] = qualify(win.east, win.north, win.north_east, win.north_west,
                       win.south_east);
    flags[3] = qualify(win.east, win.south, win.south_east, win.south_west,
                       win.north_east);
    sides[0] = win.west;
    sides[1] = win.west;
    sides[2] = win.east;
    sides[3] = win.east;
  end

  // masked channel sums and match count
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sums_next[c] = '0;
      for (int d = 0; d < NDIAG; d++) begin
        if (flags[d]) begin
          sums_next[c] = sums_next[c] +
                         {{(SUM_W-CH_W){1'b0}}, sides[d][c*CH_W +: CH_W]};
        end
      end
    end
    cnt_next = {{(CNT_W-1){1'b0}}, flags[0]} + {{(CNT_W-1){1'b0}}, flags[1]} +
               {{(CNT_W-1){1'b0}}, flags[2]} + {{(CNT_W-1){1'b0}}, flags[3]};
  end

  // stage 2: sums registered
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else begin
      sum_vld <= win_vld;
    end
    sums <= sums_next;
    cnt  <= cnt_next;
    ctr  <= win.center;
  end

  // divisor: count scaled by the inverse level, floored at one
  assign prod    = (CNT_W+INV_W)'(cnt) * (CNT_W+INV_W)'(inv_level);
  assign div_raw = prod[DIV_W+7:8];

  // stage 3: divisor registered
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= sum_vld;
    end
    acc.sums    <= sums;
    acc.divisor <= (div_raw == '0) ? {{(DIV_W-1){1'b0}}, 1'b1} : div_raw;
    acc.center  <= ctr;
    acc.hit     <= (cnt != '0);
  end

endmodule

// ===== sv/pacs_div.sv =====
// pipelined restoring divider, four channels sharing one divisor
module pacs_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_vld,
  input  pacs_pkg::acc_t acc,
  output logic           out_vld,
  output pacs_pkg::quo_t quo
);
  import pacs_pkg::*;

  localparam int STEPS  = 2;
  localparam int NSTAGE = SUM_W / STEPS;

  // stage registers, index s holds the state after s stages
  logic [NSTAGE:1]  vld;
  logic [SUM_W-1:0] num [1:NSTAGE][NCH];
  logic [SUM_W-1:0] rem [1:NSTAGE][NCH];
  logic [SUM_W-1:0] qt  [1:NSTAGE][NCH];
  logic [DIV_W-1:0] dvs [1:NSTAGE];
  logic [PIX_W-1:0] ctr [1:NSTAGE];
  logic             hit [1:NSTAGE];

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    logic             vld_in;
    logic [SUM_W-1:0] num_in [NCH];
    logic [SUM_W-1:0] rem_in [NCH];
    logic [SUM_W-1:0] qt_in  [NCH];
    logic [DIV_W-1:0] dvs_in;
    logic [PIX_W-1:0] ctr_in;
    logic             hit_in;
    logic [SUM_W-1:0] rem_next [NCH];
    logic [SUM_W-1:0] qt_next  [NCH];

    // first stage takes the request, later ones the previous stage
    if (s == 0) begin : g_head
      always_comb begin
        vld_in = in_vld;
        for (int c = 0; c < NCH; c++) begin
          num_in[c] = acc.sums[c];
          rem_in[c] = '0;
          qt_in[c]  = '0;
        end
        dvs_in = acc.divisor;
        ctr_in = acc.center;
        hit_in = acc.hit;
      end
    end else begin : g_body
      always_comb begin
        vld_in = vld[s];
        for (int c = 0; c < NCH; c++) begin
          num_in[c] = num[s][c];
          rem_in[c] = rem[s][c];
          qt_in[c]  = qt[s][c];
        end
        dvs_in = dvs[s];
        ctr_in = ctr[s];
        hit_in = hit[s];
      end
    end

    // two quotient bits per stage
    always_comb begin : p_step
      logic [SUM_W:0]   trial;
      logic [SUM_W-1:0] r;
      logic [SUM_W-1:0] q;
      for (int c = 0; c < NCH; c++) begin
        r = rem_in[c];
        q = qt_in[c];
        for (int j = 0; j < STEPS; j++) begin
          trial = {r, num_in[c][SUM_W-1-s*STEPS-j]};
          if (trial >= {1'b0, dvs_in}) begin
            trial = trial - {1'b0, dvs_in};
            q[SUM_W-1-s*STEPS-j] = 1'b1;
          end
          r = trial[SUM_W-1:0];
        end
        rem_next[c] = r;
        qt_next[c]  = q;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld_in;
      end
      for (int c = 0; c < NCH; c++) begin
        num[s+1][c] <= num_in[c];
        rem[s+1][c] <= rem_next[c];
        qt[s+1][c]  <= qt_next[c];
      end
      dvs[s+1] <= dvs_in;
      ctr[s+1] <= ctr_in;
      hit[s+1] <= hit_in;
    end
  end

  // last stage out
  always_comb begin
    out_vld = vld[NSTAGE];
    for (int c = 0; c < NCH; c++) begin
      quo.quot[c] = qt[NSTAGE][c];
    end
    quo.center = ctr[NSTAGE];
    quo.hit    = hit[NSTAGE];
  end

endmodule

// ===== sv/pacs_blend.sv =====
// saturation of the average and source-over blend onto the centre
module pacs_blend (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_vld,
  input  pacs_pkg::quo_t quo,
  output logic           out_vld,
  output pacs_pkg::out_t res
);
  import pacs_pkg::*;

  logic [NCH-1:0][CH_W-1:0] avg_next;
  logic [CH_W:0]            k;
  logic [NCH-1:0][CH_W-1:0] scaled_next;
  logic [2*CH_W:0]          prod [NCH];
  logic [NCH-1:0][CH_W-1:0] avg;
  logic [NCH-1:0][CH_W-1:0] scaled;
  logic [PIX_W-1:0]         ctr;
  logic                     hit;
  logic                     mid_vld;
  logic [PIX_W-1:0]         blended;
  logic [CH_W:0]            total;

  // average clipped to 8 bits, then centre scaled by the inverse coverage
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      avg_next[c] = (|quo.quot[c][SUM_W-1:CH_W]) ? {CH_W{1'b1}}
                                                   : quo.quot[c][CH_W-1:0];
    end
    k = 9'd256 - ({1'b0, avg_next[NCH-1]} + {{CH_W{1'b0}}, avg_next[NCH-1][CH_W-1]});
    for (int c = 0; c < NCH; c++) begin
      prod[c]        = (2*CH_W+1)'(k) * (2*CH_W+1)'(quo.center[c*CH_W +: CH_W]);
      scaled_next[c] = prod[c][2*CH_W-1:CH_W];
    end
  end

  // stage 1: average and scaled centre
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= 1'b0;
    end else begin
      mid_vld <= in_vld;
    end
    avg    <= avg_next;
    scaled <= scaled_next;
    ctr    <= quo.center;
    hit    <= quo.hit;
  end

  // add and clip each channel
  always_comb begin
    total = '0;
    for (int c = 0; c < NCH; c++) begin
      total = {1'b0, avg[c]} + {1'b0, scaled[c]};
      blended[c*CH_W +: CH_W] = total[CH_W] ? {CH_W{1'b1}} : total[CH_W-1:0];
    end
  end

  // stage 2: result, centre unchanged when nothing matched
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= mid_vld;
    end
    res.result_pixel <= hit ? blended : ctr;
    res.was_smoothed <= hit;
  end

endmodule

// ===== sv/pixel_art_corner_smoothing_unit.sv =====
// top level of the pixel-art corner smoothing unit
//
//  channel   handshake               payload                 direction
//  request   start, busy             item (in_t)             in
//  result    done (one-cycle strobe) result (out_t)          out
//  config    cfg_we                  cfg_data (inverse level) in
//
// The request edge leads to the done strobe through window capture,
// matching and divisor, then the divider at two quotient bits per stage,
// then the blend. One request is taken every cycle.
// Synchronous reset clears all valid bits and loads the inverse level 842.
// busy stays low: the pipeline never stalls, and results are shown for
// one cycle each in request order.
module pixel_art_corner_smoothing_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  pacs_pkg::in_t              item,
  input  logic                       cfg_we,
  input  logic [pacs_pkg::INV_W-1:0] cfg_data,
  output logic                       done,
  output pacs_pkg::out_t             result
);
  import pacs_pkg::*;

  logic [INV_W-1:0] inv_level;
  logic             acc_vld;
  acc_t             acc;
  logic             quo_vld;
  quo_t             quo;

  // inverse level register
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_level <= INV_RESET;
    end else if (cfg_we) begin
      inv_level <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // matching and sums
  pacs_match u_match (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (start && !busy),
    .item      (item),
    .inv_level (inv_level),
    .out_vld   (acc_vld),
    .acc       (acc)
  );

  // channel averages
  pacs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (acc_vld),
    .acc     (acc),
    .out_vld (quo_vld),
    .quo     (quo)
  );

  // blend onto the centre
  pacs_blend u_blend (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (quo_vld),
    .quo     (quo),
    .out_vld (done),
    .res     (result)
  );

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the pixel-art corner smoothing unit
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pacs_pkg::*;

  // one line of the directed table: either a register write or a window
  typedef struct {
    logic             is_cfg;
    logic [INV_W-1:0] inv;
    in_t              win;
    logic             typed;
    out_t             want;
  } smoke_row_t;

  localparam int ROUNDS      = 9;
  localparam int ROUND_ITEMS = 100;
  localparam int SETTLE      = 20;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  in_t              item = '0;
  logic             cfg_we = 1'b0;
  logic [INV_W-1:0] cfg_data = '0;
  logic             done;
  out_t             result;

  out_t             pending_pixels [$];
  smoke_row_t       smoke_rows [$];
  logic [INV_W-1:0] inv_level = INV_RESET;
  int unsigned      pixel_errors = 0;
  int unsigned      pixels_seen = 0;

  pixel_art_corner_smoothing_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one diagonal qualifies: opaque enough, equal to the vertical, not a flat corner
  function automatic logic diag_hit(logic [PIX_W-1:0] side, logic [PIX_W-1:0] vert,
                                    logic [PIX_W-1:0] corner, logic [PIX_W-1:0] across_row,
                                    logic [PIX_W-1:0] across_col);
    return side[31:24] > ALPHA_MIN && side == vert &&
           (side != corner || side != across_row || side != across_col);
  endfunction

  // expected smoothed pixel for one window at a given inverse level
  function automatic out_t smooth_window(in_t w, logic [INV_W-1:0] inv);
    logic [NCH-1:0][SUM_W-1:0] sums;
    logic [CNT_W-1:0]          hits;
    logic [NDIAG-1:0]          take;
    logic [PIX_W-1:0]          side [NDIAG];
    logic [CNT_W+INV_W-1:0]    scaled;
    logic [CNT_W+INV_W-9:0]    divisor;
    logic [CNT_W+INV_W-9:0]    quot;
    logic [CH_W-1:0]           avg [NCH];
    logic [CH_W:0]             keep;
    logic [2*CH_W:0]           prod;
    logic [CH_W:0]             mixed;
    out_t                      r;
    take[0] = diag_hit(w.west, w.north, w.north_west, w.north_east, w.south_west);
    take[1] = diag_hit(w.west, w.south, w.south_west, w.south_east, w.north_west);
    take[2] = diag_hit(w.east, w.north, w.north_east, w.north_west, w.south_east);
    take[3] = diag_hit(w.east, w.south, w.south_east, w.south_west, w.north_east);
    side = '{w.west, w.west, w.east, w.east};
    sums = '0;
    hits = '0;
    for (int d = 0; d < NDIAG; d++) begin
      if (take[d]) begin
        hits++;
        for (int ch = 0; ch < NCH; ch++) begin
          sums[ch] = sums[ch] + SUM_W'(side[d][CH_W*ch +: CH_W]);
        end
      end
    end
    r.result_pixel = w.center;
    r.was_smoothed = 1'b0;
    if (hits != 0) begin
      // count scaled by the 8.8 level, never below one
      scaled  = (CNT_W+INV_W)'(hits) * (CNT_W+INV_W)'(inv);
      divisor = scaled[CNT_W+INV_W-1:8];
      if (divisor == '0) divisor = {{(CNT_W+INV_W-9){1'b0}}, 1'b1};
      for (int ch = 0; ch < NCH; ch++) begin
        quot    = {1'b0, sums[ch]} / divisor;
        avg[ch] = (quot > 255) ? 8'hFF : quot[CH_W-1:0];
      end
      // premultiplied source-over, saturated per channel
      keep = 9'd256 - ({1'b0, avg[NCH-1]} + {{CH_W{1'b0}}, avg[NCH-1][CH_W-1]});
      for (int ch = 0; ch < NCH; ch++) begin
        prod  = (2*CH_W+1)'(keep) * (2*CH_W+1)'(w.center[CH_W*ch +: CH_W]);
        mixed = {1'b0, avg[ch]} + {1'b0, prod[2*CH_W-1:CH_W]};
        r.result_pixel[CH_W*ch +: CH_W] = mixed[CH_W] ? 8'hFF : mixed[CH_W-1:0];
      end
      r.was_smoothed = 1'b1;
    end
    return r;
  endfunction

  // random window built from a small palette so that diagonals often line up
  function automatic in_t random_window();
    logic [PIX_W-1:0] pal [4];
    logic [PIX_W-1:0] slot [9];
    logic             noise;
    pal[0] = {8'($urandom_range(255, 129)), 24'($urandom)};
    if ($urandom_range(7) == 0) pal[0][31:24] = 8'($urandom_range(130, 126));
    pal[1] = $urandom;
    pal[2] = pal[0] ^ (32'd1 << $urandom_range(31));
    pal[3] = '0;
    noise  = ($urandom_range(9) == 0);
    slot[0] = $urandom;
    for (int i = 1; i < 9; i++) begin
      if (noise || $urandom_range(9) == 0) begin
        slot[i] = $urandom;
      end else if (i <= 4 && $urandom_range(1) == 1) begin
        slot[i] = pal[0];
      end else begin
        slot[i] = pal[$urandom_range(3)];
      end
    end
    return '{slot[0], slot[1], slot[2], slot[3], slot[4], slot[5], slot[6], slot[7], slot[8]};
  endfunction

  // directed table builders
  task automatic add_inv(logic [INV_W-1:0] v);
    smoke_row_t row;
    row = '{is_cfg: 1'b1, inv: v, win: '0, typed: 1'b0, want: '0};
    smoke_rows.push_back(row);
  endtask

  task automatic add_window(logic [PIX_W-1:0] c, logic [PIX_W-1:0] n, logic [PIX_W-1:0] s,
                            logic [PIX_W-1:0] w, logic [PIX_W-1:0] e,
                            logic [PIX_W-1:0] nw, logic [PIX_W-1:0] ne,
                            logic [PIX_W-1:0] sw, logic [PIX_W-1:0] se,
                            logic typed, logic [PIX_W-1:0] px, logic sm);
    smoke_row_t row;
    row = '{is_cfg: 1'b0, inv: '0, win: '{c, n, s, w, e, nw, ne, sw, se},
            typed: typed, want: '{px, sm}};
    smoke_rows.push_back(row);
  endtask

  // sender gaps of random length, start held low
  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  // offer one request and hold it until it is taken
  task automatic send_window(in_t win, out_t want);
    start <= 1'b1;
    item  <= win;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(want);
    @(negedge clk);
  endtask

  // register write once the pipeline has drained
  task automatic write_inverse_level(logic [INV_W-1:0] v);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_data  <= v;
    inv_level = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        pixel_errors++;
        if (pixel_errors <= 10)
          $display("result %0d: unexpected pixel %h smoothed %b", pixels_seen,
                   result.result_pixel, result.was_smoothed);
      end else begin
        want = pending_pixels.pop_front();
        if (result.result_pixel !== want.result_pixel ||
            result.was_smoothed !== want.was_smoothed) begin
          pixel_errors++;
          if (pixel_errors <= 10)
            $display("result %0d: pixel exp %h got %h, smoothed exp %b got %b", pixels_seen,
                     want.result_pixel, result.result_pixel, want.was_smoothed,
                     result.was_smoothed);
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [INV_W-1:0] round_inv [ROUNDS];
    int               gap_pct;
    in_t              win;
    out_t             want;

    // reset level: three-cell diagonals, alpha boundary, flat corners
    add_window('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1, 32'h0, 1'b0);
    add_window('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1, 32'hFFFFFFFF, 1'b0);
    add_window(32'h12345678, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1, 32'h12345678, 1'b0);
    add_window(32'hA5A5A5A5, 32'h80FFFFFF, '0, 32'h80FFFFFF, '0, '0, '0, '0, '0,
               1'b1, 32'hA5A5A5A5, 1'b0);
    add_window(32'h40404040, 32'h81FFFFFF, '0, 32'h81FFFFFF, '0, '0, '0, '0, '0,
               1'b0, '0, 1'b0);
    add_window(32'h33221100, 32'hC0112233, '0, 32'hC0112233, '0, 32'hC0112233,
               32'hC0112233, 32'hC0112233, '0, 1'b1, 32'h33221100, 1'b0);
    add_window(32'h33221100, 32'hC0112233, '0, 32'hC0112233, '0, 32'hC0112233,
               32'hC0112233, 32'hC0112232, '0, 1'b0, '0, 1'b0);
    add_window(32'h0F0F0F0F, 32'hC0112232, '0, 32'hC0112233, '0, '0, '0, '0, '0,
               1'b1, 32'h0F0F0F0F, 1'b0);
    add_window(32'h10203040, 32'hE0804020, 32'hE0804020, 32'hE0804020, 32'hE0804020,
               '0, '0, '0, '0, 1'b0, '0, 1'b0);
    add_window(32'h80808080, '0, 32'h90FF00FF, 32'h90FF00FF, '0, '0, '0, '0, '0,
               1'b0, '0, 1'b0);
    add_window(32'h7F7F7F7F, 32'hFF000000, '0, '0, 32'hFF000000, '0, '0, '0, '0,
               1'b0, '0, 1'b0);
    add_window(32'h01020304, '0, 32'hC8C8C8C8, '0, 32'hC8C8C8C8, '0, '0, '0, '0,
               1'b0, '0, 1'b0);
    // not premultiplied: blend overflows
    add_window(32'hFFFFFFFF, 32'h81FFFFFF, '0, 32'h81FFFFFF, '0, '0, '0, '0, '0,
               1'b0, '0, 1'b0);
    // unit divisor: opaque average replaces the centre
    add_inv(16'd256);
    add_window(32'h12345678, 32'hFF102030, '0, 32'hFF102030, '0, '0, '0, '0, '0,
               1'b1, 32'hFF102030, 1'b1);
    add_window(32'h55555555, '1, '1, '1, '1, '0, '0, '0, '0, 1'b1, 32'hFFFFFFFF, 1'b1);
    // level below one: divisor floored, averages saturate
    add_inv(16'd0);
    add_window('0, '1, '1, '1, '1, '0, '0, '0, '0, 1'b1, 32'hFFFFFFFF, 1'b1);
    add_window(32'h20202020, 32'hC0804020, 32'hC0804020, 32'hC0804020, '0, '0, '0, '0, '0,
               1'b0, '0, 1'b0);
    add_inv(16'd1);
    add_window(32'h10203040, 32'hE0804020, 32'hE0804020, 32'hE0804020, 32'hE0804020,
               '0, '0, '0, '0, 1'b0, '0, 1'b0);
    add_inv(16'd255);
    add_window(32'h10203040, 32'hE0804020, 32'hE0804020, 32'hE0804020, 32'hE0804020,
               '0, '0, '0, '0, 1'b0, '0, 1'b0);
    // top of the range: largest divisor
    add_inv(16'hFFFF);
    add_window(32'h12345678, 32'hFF102030, '0, 32'hFF102030, '0, '0, '0, '0, '0,
               1'b0, '0, 1'b0);
    add_window(32'h9ABCDEF0, '1, '1, '1, '1, '0, '0, '0, '0, 1'b0, '0, 1'b0);
    add_window(32'hDEADBEEF, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1, 32'hDEADBEEF, 1'b0);

    round_inv = '{16'd256, 16'hFFFF, 16'd0, 16'($urandom), 16'd1, INV_RESET,
                  16'($urandom), 16'd512, 16'($urandom)};

    // reset
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (smoke_rows[i]) begin
      if (smoke_rows[i].is_cfg) begin
        write_inverse_level(smoke_rows[i].inv);
      end else begin
        want = smoke_rows[i].typed ? smoke_rows[i].want
                                   : smooth_window(smoke_rows[i].win, inv_level);
        idle_gap(18);
        send_window(smoke_rows[i].win, want);
      end
    end

    // random rounds: sender gaps light, then heavy, then none
    for (int r = 0; r < ROUNDS; r++) begin
      gap_pct = (r < 3) ? 18 : (r < 6) ? 55 : 0;
      write_inverse_level(round_inv[r]);
      for (int k = 0; k < ROUND_ITEMS; k++) begin
        win = random_window();
        idle_gap(gap_pct);
        send_window(win, smooth_window(win, inv_level));
      end
    end

    // drain and let any stray strobe show up
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    if (pixel_errors == 0 && pending_pixels.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
